[design/stam_pkg.sv]
`default_nettype none
package stam_pkg;

	// Kind of a schedule entry
	typedef enum logic [1:0] {
		KIND_EMPTY   = 2'd0,
		KIND_WEEKLY  = 2'd1,
		KIND_ONETIME = 2'd2,
		KIND_END     = 2'd3
	} kind_t;

	// One table entry, 62 bits
	typedef struct packed {
		kind_t       kind;
		logic [6:0]  mask;
		logic [10:0] minute;
		logic [31:0] when;
		logic [1:0]  task_code;
		logic [7:0]  arg;
	} sched_entry_t;

	localparam int ENTRY_W = $bits(sched_entry_t);

	// Tick sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DAY,
		ST_SPLIT,
		ST_MIN,
		ST_WALK,
		ST_FLUSH
	} stam_state_t;

	// Constant dividers done as reciprocal multiplies.
	// now / 86400 = ((now >> 7) * RECIP_675) >> 35, exact for 32-bit now
	localparam logic [25:0] RECIP_675   = 26'd50903317;
	localparam int          SHIFT_675   = 35;
	localparam logic [16:0] SEC_PER_DAY = 17'd86400;
	// d / 7 = (d * RECIP_7) >> 19, exact for 16-bit d
	localparam logic [16:0] RECIP_7     = 17'd74899;
	localparam int          SHIFT_7     = 19;
	// s / 60 = ((s >> 2) * RECIP_15) >> 19, exact for s below 86400
	localparam logic [15:0] RECIP_15    = 16'd34953;
	localparam int          SHIFT_15    = 19;

	localparam logic [10:0] LAST_MINUTE = 11'd1439;

endpackage
`default_nettype wire

[design/stam_item_if.sv]
`default_nettype none
interface stam_item_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [31:0] now_seconds;
	logic [3:0]  entry_slot;
	logic [1:0]  entry_kind;
	logic [6:0]  weekday_mask;
	logic [10:0] minute_of_day;
	logic [31:0] fire_time;
	logic [1:0]  task_code;
	logic [7:0]  task_argument;

	modport source (
		output valid, action, now_seconds, entry_slot, entry_kind, weekday_mask,
			minute_of_day, fire_time, task_code, task_argument,
		input  ready
	);

	modport sink (
		input  valid, action, now_seconds, entry_slot, entry_kind, weekday_mask,
			minute_of_day, fire_time, task_code, task_argument,
		output ready
	);
endinterface
`default_nettype wire

[design/stam_alarm_if.sv]
`default_nettype none
interface stam_alarm_if;
	logic       valid;
	logic       ready;
	logic [3:0] fired_slot;
	logic [1:0] fired_task;
	logic [7:0] fired_argument;
	logic       last_of_run;

	modport source (
		output valid, fired_slot, fired_task, fired_argument, last_of_run,
		input  ready
	);

	modport sink (
		input  valid, fired_slot, fired_task, fired_argument, last_of_run,
		output ready
	);
endinterface
`default_nettype wire

[design/stam_ram.sv]
`default_nettype none
module stam_ram #(
	parameter int WIDTH  = 62,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read, data holds while rd_en is low
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

[design/schedule_table_alarm_matcher.sv]
// Write word: taken while idle, gives no result.
// Tick word: time split steps (day; day start and weekday quotient; weekday and minutes),
// then one table entry per cycle from the table memory unless a firing waits on a stalled
// output (TABLE_ENTRIES entries at most, or up to an end entry), then a flush step.
// A firing is held until the next one is found, so last_of_run is known on output.
// Reset clears the per-entry valid bits (every entry reads as empty) and the previous time.
`default_nettype none
module schedule_table_alarm_matcher #(
	parameter int TABLE_ENTRIES = 16
) (
	input wire logic     clk,
	input wire logic     arst_n,
	stam_item_if.sink    item,
	stam_alarm_if.source alarm
);

	import stam_pkg::*;

	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	stam_state_t state_q, state_d;

	// time registers
	logic [31:0] now_q;
	logic [31:0] prev_q;
	logic [15:0] day_q;
	logic [31:0] dstart_q;
	logic [13:0] q7_q;
	logic [2:0]  wd_q;
	logic [10:0] now_min_q;
	logic [10:0] prior_min_q;
	logic        last_neg_q;

	// walk registers
	logic [AW-1:0]            idx_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic                     rd_valid_q;

	// held firing
	logic       hold_valid_q;
	logic [3:0] hold_slot_q;
	logic [1:0] hold_task_q;
	logic [7:0] hold_arg_q;

	// output register
	logic       alarm_valid_q;
	logic [3:0] alarm_slot_q;
	logic [1:0] alarm_task_q;
	logic [7:0] alarm_arg_q;
	logic       alarm_last_q;

	// memory port
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	sched_entry_t       wr_entry;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic [ENTRY_W-1:0] rd_data;

	// control
	logic item_ready;
	logic tick_go;
	logic slot_ok;
	logic advance;
	logic push;
	logic push_last;
	logic finish;
	logic out_free;
	logic at_last;

	sched_entry_t entry;
	logic         hit;
	logic         is_end;
	logic         stall;

	stam_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_ENTRIES)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_entry),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// input decode
	assign slot_ok = 32'(item.entry_slot) < TABLE_ENTRIES;
	assign tick_go = item.valid && item_ready && !item.action;
	assign wr_en   = item.valid && item_ready && item.action && slot_ok;
	assign wr_addr = AW'(item.entry_slot);

	always_comb begin
		wr_entry.kind      = kind_t'(item.entry_kind);
		wr_entry.mask      = item.weekday_mask;
		wr_entry.minute    = item.minute_of_day;
		wr_entry.when      = item.fire_time;
		wr_entry.task_code = item.task_code;
		wr_entry.arg       = item.task_argument;
	end

	// entry match; a never-written entry reads as empty
	always_comb begin
		entry = rd_valid_q ? sched_entry_t'(rd_data) : '0;
		hit   = 1'b0;
		case (entry.kind)
			KIND_WEEKLY: begin
				hit = entry.mask[wd_q] && (last_neg_q || (entry.minute > prior_min_q))
					&& (entry.minute <= now_min_q);
			end
			KIND_ONETIME: begin
				hit = (entry.when > prev_q) && (entry.when <= now_q);
			end
			default: begin
				hit = 1'b0;
			end
		endcase
		is_end = entry.kind == KIND_END;
	end

	assign out_free = !alarm_valid_q || alarm.ready;
	assign stall    = hit && hold_valid_q && !out_free;
	assign at_last  = idx_q == AW'(TABLE_ENTRIES - 1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (tick_go) begin
					state_d = ST_DAY;
				end
			end
			ST_DAY: begin
				state_d = ST_SPLIT;
			end
			ST_SPLIT: begin
				state_d = ST_MIN;
			end
			ST_MIN: begin
				state_d = ST_WALK;
			end
			ST_WALK: begin
				if (is_end || (!stall && at_last)) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!hold_valid_q || out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control outputs
	always_comb begin
		item_ready = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = '0;
		advance    = 1'b0;
		push       = 1'b0;
		push_last  = 1'b0;
		finish     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
			end
			ST_MIN: begin
				rd_en = 1'b1;
			end
			ST_WALK: begin
				if (!is_end && !stall) begin
					advance = 1'b1;
					push    = hit && hold_valid_q;
					if (!at_last) begin
						rd_en   = 1'b1;
						rd_addr = idx_q + AW'(1);
					end
				end
			end
			ST_FLUSH: begin
				if (!hold_valid_q || out_free) begin
					finish    = 1'b1;
					push      = hold_valid_q;
					push_last = 1'b1;
				end
			end
			default: begin
				item_ready = 1'b0;
			end
		endcase
	end

	assign item.ready = item_ready;

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			valid_q       <= '0;
			prev_q        <= '0;
			hold_valid_q  <= 1'b0;
			alarm_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			// clamp on accept, then take the new time once the walk ends
			if (tick_go && (prev_q > item.now_seconds)) begin
				prev_q <= item.now_seconds;
			end else if (finish) begin
				prev_q <= now_q;
			end
			if (advance && hit) begin
				hold_valid_q <= 1'b1;
			end else if (finish) begin
				hold_valid_q <= 1'b0;
			end
			if (push) begin
				alarm_valid_q <= 1'b1;
			end else if (alarm.ready) begin
				alarm_valid_q <= 1'b0;
			end
		end
	end

	// time split datapath
	logic [50:0] day_prod;
	logic [32:0] dstart_prod;
	logic [32:0] q7_prod;
	logic [31:0] sod;
	logic [31:0] pod;
	logic [16:0] q7x7;
	logic [15:0] wd_full;
	logic [30:0] now_min_prod;
	logic [30:0] prior_min_prod;

	assign day_prod       = now_q[31:7] * RECIP_675;
	assign dstart_prod    = day_q * SEC_PER_DAY;
	assign q7_prod        = day_q * RECIP_7;
	assign sod            = now_q - dstart_q;
	assign pod            = prev_q - dstart_q;
	assign q7x7           = {q7_q, 3'b000} - {3'b000, q7_q};
	assign wd_full        = day_q - q7x7[15:0];
	assign now_min_prod   = sod[16:2] * RECIP_15;
	assign prior_min_prod = pod[16:2] * RECIP_15;

	always_ff @(posedge clk) begin
		if (tick_go) begin
			now_q <= item.now_seconds;
		end
		if (state_q == ST_DAY) begin
			day_q <= day_prod[SHIFT_675 +: 16];
		end
		if (state_q == ST_SPLIT) begin
			dstart_q <= dstart_prod[31:0];
			q7_q     <= q7_prod[SHIFT_7 +: 14];
		end
		if (state_q == ST_MIN) begin
			wd_q        <= wd_full[2:0];
			now_min_q   <= now_min_prod[SHIFT_15 +: 11];
			prior_min_q <= prior_min_prod[SHIFT_15 +: 11];
			last_neg_q  <= prev_q < dstart_q;
		end
	end

	// walk index and read-side valid bit
	always_ff @(posedge clk) begin
		if (state_q == ST_MIN) begin
			idx_q <= '0;
		end else if (advance) begin
			idx_q <= idx_q + AW'(1);
		end
		if (rd_en) begin
			rd_valid_q <= valid_q[rd_addr];
		end
	end

	// held firing and output word
	always_ff @(posedge clk) begin
		if (advance && hit) begin
			hold_slot_q <= 4'(idx_q);
			hold_task_q <= entry.task_code;
			hold_arg_q  <= entry.arg;
		end
		if (push) begin
			alarm_slot_q <= hold_slot_q;
			alarm_task_q <= hold_task_q;
			alarm_arg_q  <= hold_arg_q;
			alarm_last_q <= push_last;
		end
	end

	assign alarm.valid          = alarm_valid_q;
	assign alarm.fired_slot     = alarm_slot_q;
	assign alarm.fired_task     = alarm_task_q;
	assign alarm.fired_argument = alarm_arg_q;
	assign alarm.last_of_run    = alarm_last_q;

	// a push never overwrites a word still waiting on the output
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!alarm_valid_q || alarm.ready))
		else $error("output word overwritten");

	// no firing is left held between ticks
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !hold_valid_q)
		else $error("firing held in idle");

	// table is never read and written in the same cycle
	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && wr_en))
		else $error("table read and write overlap");

	// time split results stay in range during the walk
	a_split_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> ((wd_q != 3'd7) && (now_min_q <= LAST_MINUTE)))
		else $error("weekday or minute out of range");

	// a stalled walk keeps its index
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && stall) |=> $stable(idx_q))
		else $error("walk index moved while stalled");

endmodule
`default_nettype wire

[tb/tb_schedule_table_alarm_matcher.sv]
module tb_schedule_table_alarm_matcher;
	import stam_pkg::*;

	localparam int SLOTS = 16;
	localparam int CLK_PERIOD = 10;
	localparam int unsigned DAY_SECONDS = 86400;
	localparam int unsigned WEEK_DAYS = 7;
	localparam int unsigned MINUTE_SECONDS = 60;
	localparam int MINUTES_PER_DAY = 1440;
	localparam logic [31:0] WEEK0 = 32'd604800;	// day 7, weekday 0

	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_WRITE = 1'b1;
	localparam logic [1:0] TASK_POWER_OFF = 2'd0;
	localparam logic [1:0] TASK_POWER_ON = 2'd1;
	localparam logic [1:0] TASK_HELLO = 2'd2;
	localparam logic [1:0] TASK_INTENSITY = 2'd3;

	localparam int RANDOM_WORDS = 410;
	localparam int PRESSURE_AFTER = 24;
	localparam int PRESSURE_CYCLES = 400;
	localparam int DRAIN_CYCLES = 64;
	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int MAX_REPORTS = 10;
	localparam int SIDE_SEND = 0;
	localparam int SIDE_RECV = 1;
	localparam int UNCHECKED = -1;

	typedef struct packed {
		logic        action;
		logic [31:0] now_seconds;
		logic [3:0]  entry_slot;
		kind_t       entry_kind;
		logic [6:0]  weekday_mask;
		logic [10:0] minute_of_day;
		logic [31:0] fire_time;
		logic [1:0]  task_code;
		logic [7:0]  task_argument;
	} item_word_t;

	typedef struct packed {
		logic [3:0] slot;
		logic [1:0] task_code;
		logic [7:0] arg;
		logic       last;
	} alarm_t;

	// one directed row; n_alarms is 0 or 1 when typed in, else UNCHECKED
	typedef struct {
		item_word_t word;
		int         n_alarms;
		alarm_t     alarm;
	} stim_row_t;

	logic clk;
	logic arst_n;

	stam_item_if item_bus ();
	stam_alarm_if alarm_bus ();

	schedule_table_alarm_matcher #(
		.TABLE_ENTRIES(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_bus),
		.alarm(alarm_bus)
	);

	// shadow of the schedule table and the previous tick time
	sched_entry_t sched_shadow[SLOTS];
	logic [31:0] prev_tick_time;
	alarm_t pending_alarms[$];
	stim_row_t directed[$];
	int error_count = 0;
	int idle_burst[2] = '{0, 0};

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("DONE: errors detected");
		$finish;
	end

	// random idle gap before each word, with occasional back-to-back bursts
	function automatic int draw_idle(int side);
		if (idle_burst[side] > 0) begin
			idle_burst[side]--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0) begin
			idle_burst[side] = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 15);
	endfunction

	function automatic bit count_error();
		error_count++;
		return error_count <= MAX_REPORTS;
	endfunction

	// expected alarms of one tick, in table order
	function automatic void predict_tick(logic [31:0] now, bit push);
		int unsigned day_index, day_start, weekday;
		int now_min, prior_min, minute, last_hit, i;
		bit [SLOTS-1:0] hits;
		bit walking;
		alarm_t a;
		hits = '0;
		walking = 1'b1;
		last_hit = -1;
		if (prev_tick_time > now)
			prev_tick_time = now;
		day_index = now / DAY_SECONDS;
		day_start = day_index * DAY_SECONDS;
		weekday = day_index % WEEK_DAYS;
		now_min = int'((now - day_start) / MINUTE_SECONDS);
		if (prev_tick_time < day_start)
			prior_min = -1;
		else
			prior_min = int'((prev_tick_time - day_start) / MINUTE_SECONDS);
		for (i = 0; i < SLOTS && walking; i++) begin
			case (sched_shadow[i].kind)
				KIND_END: walking = 1'b0;
				KIND_WEEKLY: begin
					minute = int'(sched_shadow[i].minute);
					hits[i] = sched_shadow[i].mask[weekday] && minute > prior_min &&
						minute <= now_min;
				end
				KIND_ONETIME: begin
					hits[i] = sched_shadow[i].when > prev_tick_time &&
						sched_shadow[i].when <= now;
				end
				default: ;
			endcase
			if (hits[i])
				last_hit = i;
		end
		for (i = 0; i <= last_hit; i++) begin
			if (hits[i] && push) begin
				a.slot = i[3:0];
				a.task_code = sched_shadow[i].task_code;
				a.arg = sched_shadow[i].arg;
				a.last = (i == last_hit);
				pending_alarms.push_back(a);
			end
		end
		prev_tick_time = now;
	endfunction

	// apply one accepted word to the shadow state
	function automatic void model_word(item_word_t w, bit push);
		if (w.action == ACT_WRITE) begin
			if (int'(w.entry_slot) < SLOTS)
				sched_shadow[w.entry_slot] = {w.entry_kind, w.weekday_mask, w.minute_of_day,
					w.fire_time, w.task_code, w.task_argument};
		end else begin
			predict_tick(w.now_seconds, push);
		end
	endfunction

	function automatic item_word_t random_word();
		item_word_t w;
		w.action = 1'($urandom_range(0, 1));
		w.now_seconds = $urandom();
		w.entry_slot = 4'($urandom_range(0, 15));
		w.entry_kind = kind_t'($urandom_range(0, 3));
		w.weekday_mask = 7'($urandom_range(0, 127));
		w.minute_of_day = 11'($urandom_range(0, 2047));
		w.fire_time = $urandom();
		w.task_code = 2'($urandom_range(0, 3));
		w.task_argument = 8'($urandom_range(0, 255));
		return w;
	endfunction

	// tick: other fields carry noise
	function automatic item_word_t tick_word(logic [31:0] now);
		item_word_t w;
		w = random_word();
		w.action = ACT_TICK;
		w.now_seconds = now;
		return w;
	endfunction

	function automatic item_word_t entry_word(logic [3:0] slot, kind_t kind, logic [6:0] mask,
			logic [10:0] minute, logic [31:0] when, logic [1:0] tcode, logic [7:0] arg);
		item_word_t w;
		w = random_word();
		w.action = ACT_WRITE;
		w.entry_slot = slot;
		w.entry_kind = kind;
		w.weekday_mask = mask;
		w.minute_of_day = minute;
		w.fire_time = when;
		w.task_code = tcode;
		w.task_argument = arg;
		return w;
	endfunction

	// entry aimed at the near future of wall, so that it is likely to fire
	function automatic item_word_t schedule_word(logic [31:0] wall, logic [3:0] slot);
		item_word_t w;
		int pick, cur_min;
		w = random_word();
		w.action = ACT_WRITE;
		w.entry_slot = slot;
		cur_min = int'((wall % DAY_SECONDS) / MINUTE_SECONDS);
		pick = $urandom_range(0, 99);
		w.weekday_mask = 7'($urandom() | $urandom());
		w.minute_of_day = 11'((cur_min + $urandom_range(0, 15)) % MINUTES_PER_DAY);
		w.fire_time = wall + $urandom_range(0, 900);
		if (pick < 48)
			w.entry_kind = KIND_WEEKLY;
		else if (pick < 88)
			w.entry_kind = KIND_ONETIME;
		else if (pick < 96)
			w.entry_kind = KIND_EMPTY;
		else
			w.entry_kind = KIND_END;
		if ($urandom_range(0, 19) == 0)
			w.minute_of_day = 11'($urandom_range(MINUTES_PER_DAY, 2047));
		return w;
	endfunction

	function automatic void add_row(item_word_t w, int n, alarm_t a);
		stim_row_t row;
		row.word = w;
		row.n_alarms = n;
		row.alarm = a;
		directed.push_back(row);
	endfunction

	// drive one word at the falling edge, hold until taken
	task automatic issue_word(input item_word_t w, input bit push);
		int gap;
		gap = draw_idle(SIDE_SEND);
		if (gap > 0) begin
			@(negedge clk);
			item_bus.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		item_bus.valid <= 1'b1;
		item_bus.action <= w.action;
		item_bus.now_seconds <= w.now_seconds;
		item_bus.entry_slot <= w.entry_slot;
		item_bus.entry_kind <= w.entry_kind;
		item_bus.weekday_mask <= w.weekday_mask;
		item_bus.minute_of_day <= w.minute_of_day;
		item_bus.fire_time <= w.fire_time;
		item_bus.task_code <= w.task_code;
		item_bus.task_argument <= w.task_argument;
		@(posedge clk);
		while (!item_bus.ready) @(posedge clk);
		model_word(w, push);
	endtask

	// mostly forward-running time with table reloads, plus noise words and jumps
	task automatic run_random();
		int sent, pick, n_writes, k;
		logic [31:0] wall, step;
		sent = 0;
		wall = $urandom();
		while (sent < RANDOM_WORDS) begin
			pick = $urandom_range(0, 99);
			if (sent == 0 || pick < 6) begin
				n_writes = ($urandom_range(0, 2) == 0) ? SLOTS : $urandom_range(1, 5);
				for (k = 0; k < n_writes; k++)
					issue_word(schedule_word(wall,
						(n_writes == SLOTS) ? k[3:0] : 4'($urandom_range(0, 15))), 1'b1);
				sent += n_writes;
			end else if (pick < 12) begin
				issue_word(random_word(), 1'b1);
				sent++;
			end else if (pick < 20) begin
				case ($urandom_range(0, 2))
					0: wall = $urandom();
					1: wall = wall - $urandom_range(1, 5000);
					default: wall = 32'hFFFF_FFFF - $urandom_range(0, 3000);
				endcase
				issue_word(tick_word(wall), 1'b1);
				sent++;
			end else begin
				pick = $urandom_range(0, 9);
				if (pick < 7)
					step = $urandom_range(1, 90);
				else if (pick < 9)
					step = $urandom_range(91, 3600);
				else
					step = $urandom_range(3601, 200000);
				wall = wall + step;
				issue_word(tick_word(wall), 1'b1);
				sent++;
			end
		end
	endtask

	// main stimulus
	initial begin : stimulus
		int r;
		arst_n = 1'b0;
		item_bus.valid = 1'b0;
		item_bus.action = ACT_TICK;
		item_bus.now_seconds = '0;
		item_bus.entry_slot = '0;
		item_bus.entry_kind = KIND_EMPTY;
		item_bus.weekday_mask = '0;
		item_bus.minute_of_day = '0;
		item_bus.fire_time = '0;
		item_bus.task_code = TASK_POWER_OFF;
		item_bus.task_argument = '0;
		for (r = 0; r < SLOTS; r++)
			sched_shadow[r] = '0;
		prev_tick_time = '0;

		// empty table, then entries at the field extremes
		add_row(tick_word(32'd0), 0, '0);
		add_row(entry_word(4'd0, KIND_WEEKLY, 7'h01, 11'd1, 32'd0, TASK_POWER_ON, 8'hA5),
			0, '0);
		add_row(entry_word(4'd15, KIND_ONETIME, 7'h7F, 11'd2047, 32'hFFFF_FFFF,
			TASK_INTENSITY, 8'hFF), 0, '0);
		add_row(entry_word(4'd1, KIND_WEEKLY, 7'h7F, 11'd1439, 32'd0, TASK_HELLO, 8'h00),
			0, '0);
		// minute out of range: stored, never fires
		add_row(entry_word(4'd2, KIND_WEEKLY, 7'h7F, 11'd2047, 32'd0, TASK_POWER_OFF, 8'h11),
			0, '0);
		add_row(entry_word(4'd3, KIND_ONETIME, 7'h00, 11'd0, WEEK0 + 32'd30, TASK_POWER_OFF,
			8'h3C), 0, '0);
		add_row(tick_word(WEEK0 + 32'd59), 1, {4'd3, TASK_POWER_OFF, 8'h3C, 1'b1});
		add_row(tick_word(WEEK0 + 32'd60), 1, {4'd0, TASK_POWER_ON, 8'hA5, 1'b1});
		// same time again: nothing new
		add_row(tick_word(WEEK0 + 32'd60), 0, '0);
		// time goes backward: previous time clamped
		add_row(tick_word(WEEK0), 0, '0);
		add_row(tick_word(WEEK0 + 32'd86399), UNCHECKED, '0);
		// end entry stops the walk before slot 5
		add_row(entry_word(4'd4, KIND_END, 7'h00, 11'd0, 32'd0, TASK_POWER_OFF, 8'h00), 0, '0);
		add_row(entry_word(4'd5, KIND_ONETIME, 7'h00, 11'd0, WEEK0 + 32'd86600, TASK_HELLO,
			8'h77), 0, '0);
		add_row(tick_word(WEEK0 + 32'd86500), 0, '0);
		// empty entry with all-ones mask, time, task and argument is skipped
		add_row(entry_word(4'd4, KIND_EMPTY, 7'h7F, 11'd0, 32'hFFFF_FFFF, TASK_INTENSITY,
			8'hFF), 0, '0);
		add_row(tick_word(WEEK0 + 32'd86650), 1, {4'd5, TASK_HELLO, 8'h77, 1'b1});
		add_row(tick_word(32'hFFFF_FFFF), 1, {4'd15, TASK_INTENSITY, 8'hFF, 1'b1});
		add_row(tick_word(32'd0), 0, '0);
		add_row(entry_word(4'd6, KIND_WEEKLY, 7'h7F, 11'd0, 32'd0, TASK_HELLO, 8'h5A), 0, '0);
		// midnight: last minute is -1, minute 0 fires
		add_row(tick_word(32'd259200), 1, {4'd6, TASK_HELLO, 8'h5A, 1'b1});
		add_row(tick_word(32'd345599), UNCHECKED, '0);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (r = 0; r < directed.size(); r++) begin
			issue_word(directed[r].word, directed[r].n_alarms == UNCHECKED);
			if (directed[r].n_alarms == 1)
				pending_alarms.push_back(directed[r].alarm);
		end
		run_random();
		@(negedge clk);
		item_bus.valid <= 1'b0;

		// drain, then give a silent tick time to finish its walk
		while (pending_alarms.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// alarm receiver: random stalls, one long hold-off to back up the block
	initial begin : alarm_sink
		int stall, taken;
		taken = 0;
		alarm_bus.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (taken == PRESSURE_AFTER)
				stall = PRESSURE_CYCLES;
			else
				stall = draw_idle(SIDE_RECV);
			if (stall > 0) begin
				@(negedge clk);
				alarm_bus.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			alarm_bus.ready <= 1'b1;
			@(posedge clk);
			while (!alarm_bus.valid) @(posedge clk);
			taken++;
		end
	end

	// compare each alarm word with the oldest expectation
	always @(posedge clk) begin : alarm_check
		alarm_t got, want;
		if (arst_n && alarm_bus.valid && alarm_bus.ready) begin
			got = {alarm_bus.fired_slot, alarm_bus.fired_task, alarm_bus.fired_argument,
				alarm_bus.last_of_run};
			if (pending_alarms.size() == 0) begin
				if (count_error())
					$display("unexpected alarm: slot %0d task %0d arg 0x%02h last %0b",
						got.slot, got.task_code, got.arg, got.last);
			end else begin
				want = pending_alarms.pop_front();
				if (got.slot !== want.slot || got.task_code !== want.task_code ||
						got.arg !== want.arg || got.last !== want.last) begin
					if (count_error())
						$display({"alarm mismatch: expected slot %0d task %0d arg 0x%02h ",
							"last %0b, got slot %0d task %0d arg 0x%02h last %0b"},
							want.slot, want.task_code, want.arg, want.last,
							got.slot, got.task_code, got.arg, got.last);
				end
			end
		end
	end

endmodule

[files.f]
design/stam_pkg.sv
design/stam_item_if.sv
design/stam_alarm_if.sv
design/stam_ram.sv
design/schedule_table_alarm_matcher.sv
tb/tb_schedule_table_alarm_matcher.sv
